[hw/rtl/mu8_pkg.sv]
`timescale 1ns / 1ps

package mu8_pkg;

    localparam int MaxBytes = 6;
    localparam int CntW     = $clog2(MaxBytes + 1);
    localparam int CpW      = 21;

    localparam logic [CpW-1:0] CpAsciiMax = 21'h00007F;
    localparam logic [CpW-1:0] CpTwoMax   = 21'h0007FF;
    localparam logic [CpW-1:0] CpBmpMax   = 21'h00FFFF;
    localparam logic [CpW-1:0] CpSurLo    = 21'h00D800;
    localparam logic [CpW-1:0] CpSurHi    = 21'h00DFFF;
    localparam logic [CpW-1:0] CpMax      = 21'h10FFFF;
    localparam logic [CpW-1:0] CpSuppBase = 21'h010000;

    localparam logic [5:0] HiSurTop = 6'b110110;
    localparam logic [5:0] LoSurTop = 6'b110111;

    localparam logic [2:0] LeadTwo   = 3'b110;
    localparam logic [3:0] LeadThree = 4'b1110;
    localparam logic [1:0] ContMark  = 2'b10;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        byte_t [MaxBytes-1:0] bytes;
        logic  [CntW-1:0]     count;
    } enc_t;

    function automatic enc_t encode(input logic [CpW-1:0] cp);
        enc_t             r;
        logic [CpW-1:0]   off;
        logic [15:0]      hi;
        logic [15:0]      lo;
        r     = '0;
        off   = cp - CpSuppBase;
        hi    = {HiSurTop, off[19:10]};
        lo    = {LoSurTop, off[9:0]};
        if (cp <= CpTwoMax && (cp == '0 || cp > CpAsciiMax)) begin
            r.bytes[0] = {LeadTwo, cp[10:6]};
            r.bytes[1] = {ContMark, cp[5:0]};
            r.count    = CntW'(2);
        end else if (cp <= CpAsciiMax) begin
            r.bytes[0] = cp[7:0];
            r.count    = CntW'(1);
        end else if (cp <= CpBmpMax) begin
            if (!(cp >= CpSurLo && cp <= CpSurHi)) begin
                r.bytes[0] = {LeadThree, cp[15:12]};
                r.bytes[1] = {ContMark, cp[11:6]};
                r.bytes[2] = {ContMark, cp[5:0]};
                r.count    = CntW'(3);
            end
        end else if (cp <= CpMax) begin
            r.bytes[0] = {LeadThree, hi[15:12]};
            r.bytes[1] = {ContMark, hi[11:6]};
            r.bytes[2] = {ContMark, hi[5:0]};
            r.bytes[3] = {LeadThree, lo[15:12]};
            r.bytes[4] = {ContMark, lo[11:6]};
            r.bytes[5] = {ContMark, lo[5:0]};
            r.count    = CntW'(6);
        end
        return r;
    endfunction

endpackage

[hw/rtl/modified_utf8_encoder_core.sv]
`timescale 1ns / 1ps

// Java modified UTF-8 encoder: one codepoint in, one to six bytes out, run_last on the
// final byte of each codepoint. U+0000 gives C0 80; lone surrogates and values above
// 10FFFF give no bytes. The bytes of a codepoint leave the output port one at a time;
// the next codepoint is taken in the same cycle as the previous one's last byte, so
// ASCII streams at one item per cycle while out_ready stays high. The rate is set by
// the single output byte port draining the run register.
module modified_utf8_encoder_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [mu8_pkg::CpW-1:0]   codepoint,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [7:0]                out_byte,
    output logic                      run_last
);
    import mu8_pkg::*;

    byte_t [MaxBytes-1:0] bytes_reg, bytes_next;
    logic  [CntW-1:0]     cnt_reg, cnt_next;
    enc_t                 enc;
    logic                 take;

    assign enc       = encode(codepoint);
    assign out_valid = (cnt_reg != '0);
    assign run_last  = (cnt_reg == CntW'(1));
    assign out_byte  = bytes_reg[0];
    assign take      = out_valid && out_ready;
    assign in_ready  = !out_valid || (out_ready && run_last);

    always_comb
    begin
        bytes_next = bytes_reg;
        cnt_next   = cnt_reg;
        if (take)
        begin
            for (int i = 0; i < MaxBytes - 1; i++)
            begin
                bytes_next[i] = bytes_reg[i+1];
            end
            bytes_next[MaxBytes-1] = '0;
            cnt_next = cnt_reg - CntW'(1);
        end
        if (in_valid && in_ready)
        begin
            bytes_next = enc.bytes;
            cnt_next   = enc.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CntW'(MaxBytes))
        else $error("byte count out of range");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("not ready while no bytes pending");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !run_last) |=> out_valid)
        else $error("run ended before last byte");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> (!out_valid || (out_ready && run_last)))
        else $error("item accepted over a pending run");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    import mu8_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int TailCycles = 20;
    localparam int RandomItems = 320;

    typedef struct packed {
        byte_t value;
        logic  last;
    } coded_byte_t;

    typedef struct packed {
        logic [CpW-1:0] cp;
        logic           drain;
    } cp_item_t;

    typedef enum logic [1:0] {
        StallNone,
        StallFrequent,
        StallLong
    } stall_mode_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_ready;
    logic [CpW-1:0] codepoint = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    logic [7:0]     out_byte;
    logic           run_last;

    logic           in_fire = 1'b0;
    int             error_count = 0;
    int             cycle_count = 0;

    cp_item_t       codepoint_queue[$];
    coded_byte_t    expected_bytes[$];

    int             burst_left = 0;
    int             gap_left = 0;
    int             mode_left = 0;
    int             stall_left = 0;
    stall_mode_t    stall_mode = StallNone;

    modified_utf8_encoder_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .codepoint (codepoint),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .run_last  (run_last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    task automatic push_byte(input byte_t value, input logic last);
        coded_byte_t b;
        b.value = value;
        b.last  = last;
        expected_bytes.push_back(b);
    endtask

    task automatic push_three(input logic [15:0] unit, input logic last);
        push_byte({4'b1110, unit[15:12]}, 1'b0);
        push_byte({2'b10, unit[11:6]}, 1'b0);
        push_byte({2'b10, unit[5:0]}, last);
    endtask

    // Expected bytes of one codepoint in modified UTF-8
    task automatic predict_run(input logic [CpW-1:0] cp);
        logic [19:0] off;
        off = 20'(cp - 21'h010000);
        if (cp == '0) begin
            push_byte(8'hC0, 1'b0);
            push_byte(8'h80, 1'b1);
        end else if (cp <= 21'h00007F) begin
            push_byte(cp[7:0], 1'b1);
        end else if (cp <= 21'h0007FF) begin
            push_byte({3'b110, cp[10:6]}, 1'b0);
            push_byte({2'b10, cp[5:0]}, 1'b1);
        end else if (cp <= 21'h00FFFF) begin
            if (cp < 21'h00D800 || cp > 21'h00DFFF)
                push_three(cp[15:0], 1'b1);
        end else if (cp <= 21'h10FFFF) begin
            push_three(16'hD800 + {6'd0, off[19:10]}, 1'b0);
            push_three(16'hDC00 + {6'd0, off[9:0]}, 1'b1);
        end
    endtask

    function automatic logic [CpW-1:0] random_codepoint();
        int unsigned pick;
        logic [CpW-1:0] cp;
        pick = $urandom_range(99);
        if (pick < 3)
            cp = '0;
        else if (pick < 30)
            cp = CpW'($urandom_range(1, 'h7F));
        else if (pick < 45)
            cp = CpW'($urandom_range('h80, 'h7FF));
        else if (pick < 55)
            cp = CpW'($urandom_range('h800, 'hD7FF));
        else if (pick < 65)
            cp = CpW'($urandom_range('hE000, 'hFFFF));
        else if (pick < 85)
            cp = CpW'($urandom_range('h10000, 'h10FFFF));
        else if (pick < 92)
            cp = CpW'($urandom_range('hD800, 'hDFFF));
        else
            cp = CpW'($urandom_range('h110000, 'h1FFFFF));
        return cp;
    endfunction

    task automatic queue_codepoint(input logic [CpW-1:0] cp, input logic drain);
        cp_item_t item;
        item.cp    = cp;
        item.drain = drain;
        codepoint_queue.push_back(item);
    endtask

    // sender: bursts with random gaps, optional drain before an item
    always @(negedge clk)
    begin : drive_codepoints
        logic           nv;
        logic [CpW-1:0] ncp;
        cp_item_t       item;
        nv  = in_valid;
        ncp = codepoint;
        if (rst_n) begin
            if (in_fire)
                nv = 1'b0;
            if (!nv) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (codepoint_queue.size() != 0 &&
                             !(codepoint_queue[0].drain && expected_bytes.size() != 0)) begin
                    item = codepoint_queue.pop_front();
                    nv   = 1'b1;
                    ncp  = item.cp;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
        in_valid  <= nv;
        codepoint <= ncp;
    end

    // receiver: stall pattern switches between modes
    always @(negedge clk)
    begin : drive_out_ready
        logic nr;
        nr = 1'b1;
        if (mode_left == 0) begin
            stall_mode = stall_mode_t'($urandom_range(2));
            mode_left  = $urandom_range(20, 80);
        end else begin
            mode_left--;
        end
        if (stall_left != 0) begin
            nr = 1'b0;
            stall_left--;
        end else begin
            case (stall_mode)
                StallFrequent:
                    if ($urandom_range(2) == 0) begin
                        nr         = 1'b0;
                        stall_left = $urandom_range(0, 2);
                    end
                StallLong:
                    if ($urandom_range(7) == 0) begin
                        nr         = 1'b0;
                        stall_left = $urandom_range(0, 11);
                    end
                default:
                    nr = 1'b1;
            endcase
        end
        out_ready <= nr;
    end

    always @(posedge clk)
    begin : check_bytes
        coded_byte_t want;
        if (!rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= in_valid && in_ready;
            if (in_valid && in_ready)
                predict_run(codepoint);
            if (out_valid && out_ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h last %0b",
                                              out_byte, run_last));
                end else begin
                    want = expected_bytes.pop_front();
                    if (out_byte !== want.value)
                        report_mismatch($sformatf("out_byte %02h, want %02h",
                                                  out_byte, want.value));
                    if (run_last !== want.last)
                        report_mismatch($sformatf("run_last %0b, want %0b on byte %02h",
                                                  run_last, want.last, want.value));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[modified_utf8_encoder_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        queue_codepoint(21'h000000, 1'b0);
        queue_codepoint(21'h000001, 1'b0);
        queue_codepoint(21'h00007F, 1'b0);
        queue_codepoint(21'h000080, 1'b0);
        queue_codepoint(21'h0007FF, 1'b0);
        queue_codepoint(21'h000800, 1'b0);
        queue_codepoint(21'h00D7FF, 1'b0);
        queue_codepoint(21'h00D800, 1'b0);
        queue_codepoint(21'h00DBFF, 1'b0);
        queue_codepoint(21'h00DC00, 1'b0);
        queue_codepoint(21'h00DFFF, 1'b0);
        queue_codepoint(21'h00E000, 1'b0);
        queue_codepoint(21'h00FFFF, 1'b0);
        queue_codepoint(21'h010000, 1'b1);
        queue_codepoint(21'h0103FF, 1'b0);
        queue_codepoint(21'h010400, 1'b0);
        queue_codepoint(21'h10FFFF, 1'b0);
        queue_codepoint(21'h110000, 1'b0);
        queue_codepoint(21'h1FFFFF, 1'b0);
        queue_codepoint(21'h155555, 1'b0);
        queue_codepoint(21'h0AAAAA, 1'b0);
        queue_codepoint(21'h000000, 1'b0);
        for (int i = 0; i < RandomItems; i++)
            queue_codepoint(random_codepoint(), (i % 100) == 50);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (codepoint_queue.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (TailCycles) @(posedge clk);

        if (error_count == 0)
            $display("[modified_utf8_encoder_core] OK");
        else
            $display("[modified_utf8_encoder_core] ERROR");
        $finish;
    end

endmodule

[modified_utf8_encoder_core.f]
hw/rtl/mu8_pkg.sv
hw/rtl/modified_utf8_encoder_core.sv
sim/testbench.sv
